/* rtl/iavs_pkg.sv */
// ----------------------------------------------------------------------------
// iavs_pkg
// Shared types, codes and constants of the idle air valve stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package iavs_pkg;

    localparam int RPM_W      = 14;
    localparam int TIME_W     = 32;
    localparam int DUTY_W     = 14;
    localparam int TARGET_W   = 13;
    localparam int LOWER_W    = 13;
    localparam int UPPER_W    = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int ACTION_W   = 4;

    // Minimum time between two duty changes, in ms.
    localparam int HOLD_PERIOD_MS = 1000;
    // Throttle above 5.00% locks out stepping.
    localparam int TPS_LOCKOUT    = 500;
    // Margin between large and small steps, in rpm.
    localparam int RPM_MARGIN     = 100;

    // Window edges at 93% and 107% of target. Divide by 100 as a multiply by
    // ceil(2^27/100) and a shift; exact for every 13-bit target.
    localparam int       DIV100_SHIFT = 27;
    localparam longint   DIV100_RECIP = ((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100;
    localparam longint   LOWER_MUL    = 93 * DIV100_RECIP;
    localparam longint   UPPER_MUL    = 107 * DIV100_RECIP;
    localparam int       EDGE_PROD_W  = 41;

    localparam int RESET_TARGET       = 1200;
    localparam int RESET_LOWER        = RESET_TARGET * 93 / 100;
    localparam int RESET_UPPER        = RESET_TARGET * 107 / 100;
    localparam int RESET_DEFAULT_DUTY = 6000;
    localparam int RESET_MIN_DUTY     = 0;
    localparam int RESET_MAX_DUTY     = 10000;
    localparam int RESET_STEP_LARGE   = 100;
    localparam int RESET_STEP_SMALL   = 25;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CRANK      = 4'd0,
        ACT_VERY_LOW   = 4'd1,
        ACT_HOLD       = 4'd2,
        ACT_WINDOW     = 4'd3,
        ACT_BIG_DOWN   = 4'd4,
        ACT_SMALL_DOWN = 4'd5,
        ACT_BIG_UP     = 4'd6,
        ACT_SMALL_UP   = 4'd7,
        ACT_LOCKOUT    = 4'd8
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_RPM      = 3'd0,
        CFG_DEFAULT_DUTY    = 3'd1,
        CFG_MIN_DUTY        = 3'd2,
        CFG_MAX_DUTY        = 3'd3,
        CFG_STEP_DOWN_LARGE = 3'd4,
        CFG_STEP_DOWN_SMALL = 3'd5,
        CFG_STEP_UP_LARGE   = 3'd6,
        CFG_STEP_UP_SMALL   = 3'd7
    } cfg_index_t;

endpackage

`default_nettype wire

/* rtl/iavs_if.sv */
// ----------------------------------------------------------------------------
// iavs_if
// Valid/ready channels of the idle air valve stepper: sample in, result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface iavs_sample_if;
    logic                          valid;
    logic                          ready;
    logic [iavs_pkg::RPM_W-1:0]    rpm;
    logic [iavs_pkg::TIME_W-1:0]   now_ms;
    logic                          cranking;
    logic [iavs_pkg::DUTY_W-1:0]   throttle;

    modport source (output valid, output rpm, output now_ms, output cranking,
                    output throttle, input ready);
    modport sink   (input valid, input rpm, input now_ms, input cranking,
                    input throttle, output ready);
endinterface

interface iavs_result_if;
    logic                           valid;
    logic                           ready;
    logic [iavs_pkg::DUTY_W-1:0]    duty;
    logic [iavs_pkg::ACTION_W-1:0]  action;

    modport source (output valid, output duty, output action, input ready);
    modport sink   (input valid, input duty, input action, output ready);
endinterface

`default_nettype wire

/* rtl/idle_air_valve_stepper_core.sv */
// ----------------------------------------------------------------------------
// idle_air_valve_stepper_core
// Idle valve duty controller: one result word per sample word.
// ----------------------------------------------------------------------------
// Each sample word (rpm, now_ms, cranking, throttle) yields one result word
// (duty, action). The block takes one sample word per cycle while the result
// side is not stalled; each word waits in a sample register that feeds
// one pass of compare, add and clamp logic into the result register, and the
// valve state (duty, time of last change) updates in that same cycle so that
// the next word sees it. The sample register keeps taking a word while a
// finished result waits downstream; input ready drops only when both stages
// are full and the result is stalled. Configuration writes are taken at any
// time but must be issued only while no word is in flight. The window edges
// (93% and 107% of target) are worked out and stored when the target is
// written, so the per-sample path holds no divide, only compares, adds and x10/x7 multiplies.
// ----------------------------------------------------------------------------
`default_nettype none

module idle_air_valve_stepper_core #(
    parameter int HOLD_PERIOD_MS = iavs_pkg::HOLD_PERIOD_MS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [iavs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [iavs_pkg::CFG_DATA_W-1:0] cfg_data,
    iavs_sample_if.sink                          sample,
    iavs_result_if.source                        result
);

    localparam int DW  = iavs_pkg::DUTY_W;
    localparam int SW  = DW + 2;   // signed width of the wanted duty

    // Configuration, with window edges precomputed.
    logic [iavs_pkg::LOWER_W-1:0] lower_reg;
    logic [iavs_pkg::UPPER_W-1:0] upper_reg;
    logic [DW-1:0] default_duty_reg;
    logic [DW-1:0] min_duty_reg;
    logic [DW-1:0] max_duty_reg;
    logic [DW-1:0] step_down_large_reg;
    logic [DW-1:0] step_down_small_reg;
    logic [DW-1:0] step_up_large_reg;
    logic [DW-1:0] step_up_small_reg;

    // Valve state.
    logic [DW-1:0]                 valve_duty_reg;
    logic [DW-1:0]                 valve_duty_next;
    logic [iavs_pkg::TIME_W-1:0]   last_change_reg;
    logic [iavs_pkg::TIME_W-1:0]   last_change_next;

    // Sample stage.
    logic                          in_valid_reg;
    logic [iavs_pkg::RPM_W-1:0]    rpm_reg;
    logic [iavs_pkg::TIME_W-1:0]   now_reg;
    logic                          cranking_reg;
    logic [DW-1:0]                 throttle_reg;

    // Result stage.
    logic                          out_valid_reg;
    logic [DW-1:0]                 duty_reg;
    iavs_pkg::action_t             action_reg;

    logic                          advance;
    logic                          fire;
    logic                          take_sample;

    logic [iavs_pkg::EDGE_PROD_W-1:0] lower_prod;
    logic [iavs_pkg::EDGE_PROD_W-1:0] upper_prod;

    // Decision path.
    logic [iavs_pkg::RPM_W+3:0]    rpm_x10;
    logic [iavs_pkg::LOWER_W+2:0]  lower_x7;
    logic [iavs_pkg::TIME_W-1:0]   elapsed;
    logic [iavs_pkg::UPPER_W:0]    upper_margin;
    logic [iavs_pkg::RPM_W:0]      rpm_margin;
    logic                          apply;
    logic signed [SW-1:0]          wanted;
    logic signed [SW-1:0]          clamped;
    logic [DW-1:0]                 duty_calc;
    iavs_pkg::action_t             action_calc;

    // ------------------------------------------------------------------
    // Handshake: advance the result stage when it is empty or being taken,
    // refill the sample stage whenever its word moves on.
    // ------------------------------------------------------------------
    assign advance      = !out_valid_reg || result.ready;
    assign fire         = in_valid_reg && advance;
    assign sample.ready = !in_valid_reg || advance;
    assign take_sample  = sample.valid && sample.ready;

    assign result.valid  = out_valid_reg;
    assign result.duty   = duty_reg;
    assign result.action = action_reg;

    // ------------------------------------------------------------------
    // Configuration. Window edges: floor(t*93/100) and floor(t*107/100),
    // each as one constant multiply and a shift.
    // ------------------------------------------------------------------
    assign lower_prod = iavs_pkg::EDGE_PROD_W'(cfg_data[iavs_pkg::TARGET_W-1:0])
                      * iavs_pkg::EDGE_PROD_W'(iavs_pkg::LOWER_MUL);
    assign upper_prod = iavs_pkg::EDGE_PROD_W'(cfg_data[iavs_pkg::TARGET_W-1:0])
                      * iavs_pkg::EDGE_PROD_W'(iavs_pkg::UPPER_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg           <= iavs_pkg::LOWER_W'(iavs_pkg::RESET_LOWER);
            upper_reg           <= iavs_pkg::UPPER_W'(iavs_pkg::RESET_UPPER);
            default_duty_reg    <= DW'(iavs_pkg::RESET_DEFAULT_DUTY);
            min_duty_reg        <= DW'(iavs_pkg::RESET_MIN_DUTY);
            max_duty_reg        <= DW'(iavs_pkg::RESET_MAX_DUTY);
            step_down_large_reg <= DW'(iavs_pkg::RESET_STEP_LARGE);
            step_down_small_reg <= DW'(iavs_pkg::RESET_STEP_SMALL);
            step_up_large_reg   <= DW'(iavs_pkg::RESET_STEP_LARGE);
            step_up_small_reg   <= DW'(iavs_pkg::RESET_STEP_SMALL);
        end
        else if (cfg_wr_en)
        begin
            unique case (iavs_pkg::cfg_index_t'(cfg_index))
                iavs_pkg::CFG_TARGET_RPM:
                begin
                    lower_reg <= lower_prod[iavs_pkg::DIV100_SHIFT +: iavs_pkg::LOWER_W];
                    upper_reg <= upper_prod[iavs_pkg::DIV100_SHIFT +: iavs_pkg::UPPER_W];
                end
                iavs_pkg::CFG_DEFAULT_DUTY:    default_duty_reg    <= cfg_data;
                iavs_pkg::CFG_MIN_DUTY:        min_duty_reg        <= cfg_data;
                iavs_pkg::CFG_MAX_DUTY:        max_duty_reg        <= cfg_data;
                iavs_pkg::CFG_STEP_DOWN_LARGE: step_down_large_reg <= cfg_data;
                iavs_pkg::CFG_STEP_DOWN_SMALL: step_down_small_reg <= cfg_data;
                iavs_pkg::CFG_STEP_UP_LARGE:   step_up_large_reg   <= cfg_data;
                iavs_pkg::CFG_STEP_UP_SMALL:   step_up_small_reg   <= cfg_data;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Decision: tests in priority order, then one signed add and the clamp.
    // ------------------------------------------------------------------
    assign rpm_x10      = (iavs_pkg::RPM_W+4)'(rpm_reg) * (iavs_pkg::RPM_W+4)'(10);
    assign lower_x7     = (iavs_pkg::LOWER_W+3)'(lower_reg) * (iavs_pkg::LOWER_W+3)'(7);
    assign elapsed      = now_reg - last_change_reg;
    assign upper_margin = (iavs_pkg::UPPER_W+1)'(upper_reg)
                        + (iavs_pkg::UPPER_W+1)'(iavs_pkg::RPM_MARGIN);
    assign rpm_margin   = (iavs_pkg::RPM_W+1)'(rpm_reg)
                        + (iavs_pkg::RPM_W+1)'(iavs_pkg::RPM_MARGIN);

    always_comb
    begin
        apply       = 1'b0;
        wanted      = signed'({2'b00, default_duty_reg});
        action_calc = iavs_pkg::ACT_CRANK;
        priority if (rpm_reg == '0 || cranking_reg)
        begin
            apply       = 1'b1;
            action_calc = iavs_pkg::ACT_CRANK;
        end
        else if ((iavs_pkg::RPM_W+4)'(lower_x7) > rpm_x10)
        begin
            // Seriously low: fall back to the default duty.
            apply       = 1'b1;
            action_calc = iavs_pkg::ACT_VERY_LOW;
        end
        else if (elapsed < iavs_pkg::TIME_W'(HOLD_PERIOD_MS))
        begin
            action_calc = iavs_pkg::ACT_HOLD;
        end
        else if (iavs_pkg::RPM_W'(lower_reg) < rpm_reg && rpm_reg < upper_reg)
        begin
            action_calc = iavs_pkg::ACT_WINDOW;
        end
        else
        begin
            apply = 1'b1;
            priority if ((iavs_pkg::UPPER_W+1)'(rpm_reg) >= upper_margin)
            begin
                wanted      = signed'({2'b00, valve_duty_reg})
                            - signed'({2'b00, step_down_large_reg});
                action_calc = iavs_pkg::ACT_BIG_DOWN;
            end
            else if (rpm_reg >= upper_reg)
            begin
                wanted      = signed'({2'b00, valve_duty_reg})
                            - signed'({2'b00, step_down_small_reg});
                action_calc = iavs_pkg::ACT_SMALL_DOWN;
            end
            else if (rpm_margin < (iavs_pkg::RPM_W+1)'(lower_reg))
            begin
                wanted      = signed'({2'b00, valve_duty_reg})
                            + signed'({2'b00, step_up_large_reg});
                action_calc = iavs_pkg::ACT_BIG_UP;
            end
            else
            begin
                wanted      = signed'({2'b00, valve_duty_reg})
                            + signed'({2'b00, step_up_small_reg});
                action_calc = iavs_pkg::ACT_SMALL_UP;
            end
            // Open throttle: drop the step, keep the duty.
            if (throttle_reg > DW'(iavs_pkg::TPS_LOCKOUT))
            begin
                apply       = 1'b0;
                action_calc = iavs_pkg::ACT_LOCKOUT;
            end
        end
    end

    // Raise to min first, then lower to max: max wins when bounds cross.
    always_comb
    begin
        clamped = wanted;
        if (clamped < signed'({2'b00, min_duty_reg}))
        begin
            clamped = signed'({2'b00, min_duty_reg});
        end
        if (clamped > signed'({2'b00, max_duty_reg}))
        begin
            clamped = signed'({2'b00, max_duty_reg});
        end
    end

    always_comb
    begin
        duty_calc        = valve_duty_reg;
        last_change_next = last_change_reg;
        if (apply)
        begin
            duty_calc = clamped[DW-1:0];
            // Record the time only on a real change.
            if (clamped[DW-1:0] != valve_duty_reg)
            begin
                last_change_next = now_reg;
            end
        end
        valve_duty_next = duty_calc;
    end

    // ------------------------------------------------------------------
    // Control and state registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            valve_duty_reg  <= DW'(iavs_pkg::RESET_DEFAULT_DUTY);
            last_change_reg <= '0;
        end
        else
        begin
            if (take_sample)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                valve_duty_reg  <= valve_duty_next;
                last_change_reg <= last_change_next;
            end
        end
    end

    // Payload registers: hold the sample word and the result word.
    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            rpm_reg      <= sample.rpm;
            now_reg      <= sample.now_ms;
            cranking_reg <= sample.cranking;
            throttle_reg <= sample.throttle;
        end
        if (fire)
        begin
            duty_reg   <= duty_calc;
            action_reg <= action_calc;
        end
    end

endmodule

`default_nettype wire

/* rtl/iavs_checker.sv */
// ----------------------------------------------------------------------------
// iavs_checker
// Port-level assertions for the idle air valve stepper, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module iavs_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            res_valid,
    input wire logic                            res_ready,
    input wire logic [iavs_pkg::DUTY_W-1:0]     res_duty,
    input wire logic [iavs_pkg::ACTION_W-1:0]   res_action
);

    logic                        seen_reg;
    logic [iavs_pkg::DUTY_W-1:0] last_duty_reg;
    logic                        keep_action;

    assign keep_action = res_action == iavs_pkg::ACT_HOLD
                      || res_action == iavs_pkg::ACT_WINDOW
                      || res_action == iavs_pkg::ACT_LOCKOUT;

    // Track the duty of the last delivered word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            last_duty_reg <= '0;
        end
        else if (res_valid && res_ready)
        begin
            seen_reg      <= 1'b1;
            last_duty_reg <= res_duty;
        end
    end

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_duty) && $stable(res_action))
        else $error("stalled result word changed");

    a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_action <= iavs_pkg::ACTION_W'(iavs_pkg::ACT_LOCKOUT))
        else $error("result action code out of range");

    a_duty_kept: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && seen_reg && keep_action |-> res_duty == last_duty_reg)
        else $error("duty moved on a hold, window or lockout word");

endmodule

bind idle_air_valve_stepper_core iavs_checker u_iavs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_duty   (result.duty),
    .res_action (result.action)
);

`default_nettype wire

/* tb/idle_air_valve_stepper_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// idle_air_valve_stepper_core_tb
// Self-checking bench for the idle air valve duty controller.
// ----------------------------------------------------------------------------
// Sample words go in through the valid/ready sample channel, and every
// accepted word is run through a duty predictor. The predictor keeps its own
// copy of the registers, the valve duty and the time of the last change.
// Each result word is then compared field by field with the oldest
// prediction. A directed opening under the reset registers comes first. Then
// come phases of random words, the first under the reset registers, each later
// one under a different register setting loaded while the block is drained.
// The sender idles in bursts, and the receiver stalls on a rotating pattern.
// ----------------------------------------------------------------------------

module idle_air_valve_stepper_core_tb;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 10;
    localparam int RESULT_LATENCY = 2;
    localparam int PHASE_WORDS    = 250;
    localparam int CYCLE_LIMIT    = 400000;

    typedef struct packed {
        logic [iavs_pkg::DUTY_W-1:0] duty;
        iavs_pkg::action_t           action;
    } duty_word_t;

    // ------------------------------------------------------------------------
    // Duty predictor: one expected result word per accepted sample word.
    // ------------------------------------------------------------------------
    class idle_duty_predictor;
        int                          target_rpm;
        int                          default_duty;
        int                          min_duty;
        int                          max_duty;
        int                          down_large;
        int                          down_small;
        int                          up_large;
        int                          up_small;
        int                          valve_duty;
        logic [iavs_pkg::TIME_W-1:0] last_change_ms;
        duty_word_t                  expected_words[$];
        int                          fail_count;

        function new();
            target_rpm     = iavs_pkg::RESET_TARGET;
            default_duty   = iavs_pkg::RESET_DEFAULT_DUTY;
            min_duty       = iavs_pkg::RESET_MIN_DUTY;
            max_duty       = iavs_pkg::RESET_MAX_DUTY;
            down_large     = iavs_pkg::RESET_STEP_LARGE;
            down_small     = iavs_pkg::RESET_STEP_SMALL;
            up_large       = iavs_pkg::RESET_STEP_LARGE;
            up_small       = iavs_pkg::RESET_STEP_SMALL;
            valve_duty     = iavs_pkg::RESET_DEFAULT_DUTY;
            last_change_ms = '0;
            fail_count     = 0;
        endfunction

        function void set_reg(iavs_pkg::cfg_index_t idx,
                              logic [iavs_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                iavs_pkg::CFG_TARGET_RPM:
                    target_rpm   = int'(value[iavs_pkg::TARGET_W-1:0]);
                iavs_pkg::CFG_DEFAULT_DUTY:    default_duty = int'(value);
                iavs_pkg::CFG_MIN_DUTY:        min_duty     = int'(value);
                iavs_pkg::CFG_MAX_DUTY:        max_duty     = int'(value);
                iavs_pkg::CFG_STEP_DOWN_LARGE: down_large   = int'(value);
                iavs_pkg::CFG_STEP_DOWN_SMALL: down_small   = int'(value);
                iavs_pkg::CFG_STEP_UP_LARGE:   up_large     = int'(value);
                iavs_pkg::CFG_STEP_UP_SMALL:   up_small     = int'(value);
                default: ;
            endcase
        endfunction

        // Clamp up to the floor, then down to the ceiling; the ceiling wins
        // when the two cross. Only a real change restarts the hold period.
        function int settle_duty(int wanted, logic [iavs_pkg::TIME_W-1:0] now_ms);
            int v;
            v = wanted;
            if (v < min_duty) v = min_duty;
            if (v > max_duty) v = max_duty;
            if (v != valve_duty) last_change_ms = now_ms;
            valve_duty = v;
            return v;
        endfunction

        function void note_sample(logic [iavs_pkg::RPM_W-1:0] rpm,
                                  logic [iavs_pkg::TIME_W-1:0] now_ms,
                                  logic cranking,
                                  logic [iavs_pkg::DUTY_W-1:0] throttle);
            int                          r;
            int                          lower;
            int                          upper;
            int                          step;
            int                          duty;
            iavs_pkg::action_t           act;
            logic [iavs_pkg::TIME_W-1:0] elapsed;
            r       = int'(rpm);
            lower   = target_rpm * 93 / 100;
            upper   = target_rpm * 107 / 100;
            elapsed = now_ms - last_change_ms;
            if (r == 0 || cranking)
            begin
                duty = settle_duty(default_duty, now_ms);
                act  = iavs_pkg::ACT_CRANK;
            end
            else if (r * 10 < lower * 7)
            begin
                duty = settle_duty(default_duty, now_ms);
                act  = iavs_pkg::ACT_VERY_LOW;
            end
            else if (elapsed < iavs_pkg::HOLD_PERIOD_MS)
            begin
                duty = valve_duty;
                act  = iavs_pkg::ACT_HOLD;
            end
            else if (r > lower && r < upper)
            begin
                duty = valve_duty;
                act  = iavs_pkg::ACT_WINDOW;
            end
            else
            begin
                if (r >= upper + iavs_pkg::RPM_MARGIN)
                begin
                    step = -down_large;
                    act  = iavs_pkg::ACT_BIG_DOWN;
                end
                else if (r >= upper)
                begin
                    step = -down_small;
                    act  = iavs_pkg::ACT_SMALL_DOWN;
                end
                else if (r + iavs_pkg::RPM_MARGIN < lower)
                begin
                    step = up_large;
                    act  = iavs_pkg::ACT_BIG_UP;
                end
                else
                begin
                    step = up_small;
                    act  = iavs_pkg::ACT_SMALL_UP;
                end
                if (int'(throttle) > iavs_pkg::TPS_LOCKOUT)
                begin
                    duty = valve_duty;
                    act  = iavs_pkg::ACT_LOCKOUT;
                end
                else
                begin
                    duty = settle_duty(valve_duty + step, now_ms);
                end
            end
            expected_words.push_back('{duty: duty[iavs_pkg::DUTY_W-1:0], action: act});
        endfunction

        function void check_result(logic [iavs_pkg::DUTY_W-1:0] duty,
                                   logic [iavs_pkg::ACTION_W-1:0] action);
            duty_word_t exp_word;
            if (expected_words.size() == 0)
            begin
                $error("result word with none expected: duty %0d action %0d", duty, action);
                fail_count++;
                return;
            end
            exp_word = expected_words.pop_front();
            if (duty !== exp_word.duty)
            begin
                $error("duty: expected %0d, got %0d", exp_word.duty, duty);
                fail_count++;
            end
            if (action !== exp_word.action)
            begin
                $error("action: expected %0d, got %0d", exp_word.action, action);
                fail_count++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_wr_en;
    iavs_pkg::cfg_index_t            cfg_index;
    logic [iavs_pkg::CFG_DATA_W-1:0] cfg_data;

    iavs_sample_if sample_ch ();
    iavs_result_if result_ch ();

    idle_duty_predictor predictor = new();

    logic [iavs_pkg::TIME_W-1:0] now_clock;
    int                          burst_left;
    logic [7:0]                  rx_tick = '0;
    int                          cycle_count = 0;

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    idle_air_valve_stepper_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: check every accepted result word, and stall on a rotating
    // pattern of stretches picked by the top two bits of rx_tick: always ready,
    // coin flip, mostly stalled (ready only when rx_tick[2:0] is zero), mostly ready.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (result_ch.valid && result_ch.ready)
            predictor.check_result(result_ch.duty, result_ch.action);
        rx_tick <= rx_tick + 8'd1;
        case (rx_tick[7:6])
            2'd0:    result_ch.ready <= 1'b1;
            2'd1:    result_ch.ready <= 1'($urandom_range(0, 1));
            2'd2:    result_ch.ready <= (rx_tick[2:0] == 3'd0);
            default: result_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Hold the word on the channel until it is taken, then predict its result.
    task automatic send_sample(input logic [iavs_pkg::RPM_W-1:0] rpm,
                               input logic [iavs_pkg::TIME_W-1:0] now_ms,
                               input logic cranking,
                               input logic [iavs_pkg::DUTY_W-1:0] throttle);
        sample_ch.valid    <= 1'b1;
        sample_ch.rpm      <= rpm;
        sample_ch.now_ms   <= now_ms;
        sample_ch.cranking <= cranking;
        sample_ch.throttle <= throttle;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
        predictor.note_sample(rpm, now_ms, cranking, throttle);
        // Close the burst after its last word: drop valid for a random gap.
        // A gap of zero keeps valid high into the next burst.
        burst_left--;
        if (burst_left <= 0)
        begin
            int gap;
            gap        = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        while (predictor.expected_words.size() != 0) @(posedge clk);
    endtask

    // Load all eight registers while no word is in flight. Write enable stays
    // high across the run of writes and drops once after the last.
    task automatic load_registers(input int target, input int dflt, input int lo, input int hi,
                                  input int dn_l, input int dn_s, input int up_l, input int up_s);
        logic [iavs_pkg::CFG_DATA_W-1:0] value [8];
        value[iavs_pkg::CFG_TARGET_RPM]      = iavs_pkg::CFG_DATA_W'(target);
        value[iavs_pkg::CFG_DEFAULT_DUTY]    = iavs_pkg::CFG_DATA_W'(dflt);
        value[iavs_pkg::CFG_MIN_DUTY]        = iavs_pkg::CFG_DATA_W'(lo);
        value[iavs_pkg::CFG_MAX_DUTY]        = iavs_pkg::CFG_DATA_W'(hi);
        value[iavs_pkg::CFG_STEP_DOWN_LARGE] = iavs_pkg::CFG_DATA_W'(dn_l);
        value[iavs_pkg::CFG_STEP_DOWN_SMALL] = iavs_pkg::CFG_DATA_W'(dn_s);
        value[iavs_pkg::CFG_STEP_UP_LARGE]   = iavs_pkg::CFG_DATA_W'(up_l);
        value[iavs_pkg::CFG_STEP_UP_SMALL]   = iavs_pkg::CFG_DATA_W'(up_s);
        sample_ch.valid <= 1'b0;
        wait_drained();
        repeat (RESULT_LATENCY) @(posedge clk);
        for (int i = 0; i < 8; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= iavs_pkg::cfg_index_t'(i);
            cfg_data  <= value[i];
            @(posedge clk);
            predictor.set_reg(iavs_pkg::cfg_index_t'(i), value[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Random words, mostly rpm near the target window and time advancing
    // around the hold period, so steps and holds both come often.
    task automatic run_phase(input int n_words, input logic [iavs_pkg::TIME_W-1:0] start_ms);
        int                          kind;
        int                          spread;
        int                          v;
        int                          lower;
        int                          upper;
        logic [iavs_pkg::DUTY_W-1:0] throttle;
        logic                        cranking;
        now_clock = start_ms;
        lower     = predictor.target_rpm * 93 / 100;
        upper     = predictor.target_rpm * 107 / 100;
        spread    = predictor.target_rpm * 2 / 5 + 200;
        for (int n = 0; n < n_words; n++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 10)
            begin
                v = $urandom_range(0, 16383);
            end
            else if (kind < 14)
            begin
                v = 0;
            end
            else if (kind < 30)
            begin
                // Land on or next to an edge of the decision ladder.
                case ($urandom_range(0, 4))
                    0:       v = lower;
                    1:       v = upper;
                    2:       v = upper + iavs_pkg::RPM_MARGIN;
                    3:       v = lower - iavs_pkg::RPM_MARGIN;
                    default: v = lower * 7 / 10;
                endcase
                v = v + $urandom_range(0, 2) - 1;
            end
            else
            begin
                v = predictor.target_rpm - spread + $urandom_range(0, 2 * spread);
            end
            if (v < 0) v = $urandom_range(0, 50);
            if (v > 16383) v = 16383;

            kind = $urandom_range(0, 99);
            if (kind < 70)
                throttle = iavs_pkg::DUTY_W'($urandom_range(0, iavs_pkg::TPS_LOCKOUT));
            else if (kind < 95)
                throttle = iavs_pkg::DUTY_W'($urandom_range(iavs_pkg::TPS_LOCKOUT + 1, 10000));
            else
                throttle = iavs_pkg::DUTY_W'($urandom_range(0, 16383));
            cranking = ($urandom_range(0, 99) < 6);

            kind = $urandom_range(0, 99);
            if (kind < 50)      now_clock += $urandom_range(900, 1200);
            else if (kind < 80) now_clock += $urandom_range(0, 900);
            else if (kind < 95) now_clock += $urandom_range(1200, 5000);
            else                now_clock += $urandom;

            send_sample(iavs_pkg::RPM_W'(v), now_clock, cranking, throttle);

            // Midway, let the pipe run dry once before carrying on.
            if (n == n_words / 2)
            begin
                sample_ch.valid <= 1'b0;
                wait_drained();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_index          <= iavs_pkg::CFG_TARGET_RPM;
        cfg_data           <= '0;
        sample_ch.valid    <= 1'b0;
        sample_ch.rpm      <= '0;
        sample_ch.now_ms   <= '0;
        sample_ch.cranking <= 1'b0;
        sample_ch.throttle <= '0;
        burst_left         = 1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening under reset registers: window strictly between 1116 and 1284, very low
        // below 782 rpm, duty 6000, last change at time zero.
        send_sample(14'd0,     32'd0,          1'b0, 14'd0);     // zero rpm
        send_sample(14'd16383, 32'd0,          1'b1, 14'd0);     // cranking at top rpm
        send_sample(14'd500,   32'd10,         1'b0, 14'd0);     // seriously low
        send_sample(14'd1200,  32'd500,        1'b0, 14'd0);     // inside hold
        send_sample(14'd1200,  32'd1000,       1'b0, 14'd0);     // hold just over, in window
        send_sample(14'd1116,  32'd1000,       1'b0, 14'd0);     // on lower edge: small up
        send_sample(14'd1284,  32'd1999,       1'b0, 14'd0);     // hold, one ms short
        send_sample(14'd1284,  32'd2000,       1'b0, 14'd0);     // on upper edge: small down
        send_sample(14'd1384,  32'd3000,       1'b0, 14'd0);     // upper plus margin: big down
        send_sample(14'd1015,  32'd4000,       1'b0, 14'd0);     // just beyond margin: big up
        send_sample(14'd1016,  32'd5000,       1'b0, 14'd0);     // at margin: small up
        send_sample(14'd2000,  32'd6000,       1'b0, 14'd501);   // throttle lockout
        send_sample(14'd2000,  32'd7000,       1'b0, 14'd500);   // throttle at limit steps
        send_sample(14'd16383, 32'd8000,       1'b0, 14'd10000); // lockout at full throttle
        send_sample(14'd1283,  32'd9000,       1'b0, 14'd16383); // window beats throttle
        send_sample(14'd782,   32'hFFFF_FFFF,  1'b0, 14'd0);     // low but not very low
        send_sample(14'd1400,  32'd742,        1'b0, 14'd0);     // hold across time wrap
        send_sample(14'd1400,  32'd999,        1'b0, 14'd0);     // hold over after wrap
        send_sample(14'd781,   32'd5000,       1'b0, 14'd0);     // very low edge
        send_sample(14'h2AAA,  32'hAAAA_5555,  1'b0, 14'h1555);  // bit pattern, lockout
        send_sample(14'h1555,  32'h5555_AAAA,  1'b0, 14'h2AAA);  // bit pattern, lockout
        send_sample(14'h1555,  32'h5556_AAAA,  1'b0, 14'd0);     // big down applied
        send_sample(14'd1,     32'h5557_0000,  1'b0, 14'd0);     // one rpm: very low

        run_phase(PHASE_WORDS, 32'd100000);

        // High target and full-scale steps: clamps hit at both ends.
        load_registers(8000, 10000, 0, 10000, 10000, 10000, 10000, 10000);
        run_phase(PHASE_WORDS, 32'hFFFF_F000);

        // Zero target, crossed clamps, zero steps.
        load_registers(0, 5000, 9000, 1000, 0, 0, 0, 0);
        run_phase(PHASE_WORDS, 32'd0);

        // Largest target, zero default duty and every other duty register at its top code.
        load_registers(8191, 0, 16383, 16383, 16383, 16383, 16383, 16383);
        run_phase(PHASE_WORDS, 32'h8000_0000);

        // Small target: lower edge under the rpm margin.
        load_registers(100, 3000, 2000, 4000, 500, 50, 700, 70);
        run_phase(PHASE_WORDS, 32'h0001_0000);

        repeat (2)
        begin
            load_registers($urandom_range(0, 8000), $urandom_range(0, 10000),
                           $urandom_range(0, 5000), $urandom_range(5000, 10000),
                           $urandom_range(0, 1000), $urandom_range(0, 1000),
                           $urandom_range(0, 1000), $urandom_range(0, 1000));
            run_phase(PHASE_WORDS, $urandom);
        end

        // Drain, then give any stray word time to show up.
        sample_ch.valid <= 1'b0;
        wait_drained();
        repeat (RESULT_LATENCY + 8) @(posedge clk);
        while (predictor.expected_words.size() != 0)
        begin
            duty_word_t lost;
            lost = predictor.expected_words.pop_front();
            $error("expected word never came: duty %0d action %0d", lost.duty, lost.action);
            predictor.fail_count++;
        end

        if (predictor.fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
